// ===== rtl/tbp_pkg.sv =====
// Package for the tournament branch predictor.
// Holds default table sizes, field widths, command codes and the saturating counter helpers.
// It depends on nothing else.
package tbp_pkg;

  localparam int unsigned LOCAL_ENTRIES_DEF  = 1024;
  localparam int unsigned GLOBAL_ENTRIES_DEF = 4096;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LHIST_W = 10;
  localparam int unsigned PATH_W  = 12;
  localparam int unsigned LCNT_W  = 3;
  localparam int unsigned GCNT_W  = 2;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  function automatic logic [LCNT_W-1:0] sat_lcnt(input logic [LCNT_W-1:0] v, input logic up);
    logic [LCNT_W-1:0] r;
    r = v;
    if (up) begin
      if (v != '1) r = v + 1'b1;
    end else begin
      if (v != '0) r = v - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [GCNT_W-1:0] sat_gcnt(input logic [GCNT_W-1:0] v, input logic up);
    logic [GCNT_W-1:0] r;
    r = v;
    if (up) begin
      if (v != '1) r = v + 1'b1;
    end else begin
      if (v != '0) r = v - 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tournament_branch_predictor_unit.sv =====
// Tournament branch predictor: local, global and choice tables in synchronous memories.
// A predict item passes the S_HIST and S_CNT states before it raises out_valid; an update
// returns none. A new item is taken only when the last is done, set by the dependent reads
// of the history memory and then the local counter memory; a predict waits in its last stage
// while an earlier result is stalled. Reset is synchronous; afterwards a clearing pass zeroes
// all max(LOCAL_ENTRIES, GLOBAL_ENTRIES) entries (4096 by default) of the tables while
// in_stall stays high. Depends on tbp_pkg.
module tournament_branch_predictor_unit #(
  parameter int unsigned LOCAL_ENTRIES  = tbp_pkg::LOCAL_ENTRIES_DEF,
  parameter int unsigned GLOBAL_ENTRIES = tbp_pkg::GLOBAL_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      cmd,
  input  logic [tbp_pkg::ADDR_W-1:0] branch_address,
  input  logic                      conditional,
  input  logic                      taken,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      prediction,
  output logic                      local_guess,
  output logic                      global_guess
);
  import tbp_pkg::*;

  localparam int unsigned LW   = $clog2(LOCAL_ENTRIES);
  localparam int unsigned GW   = $clog2(GLOBAL_ENTRIES);
  localparam int unsigned LA   = (LW < LHIST_W) ? LW : LHIST_W;
  localparam int unsigned GA   = (GW < PATH_W) ? GW : PATH_W;
  localparam int unsigned MW   = (LW > GW) ? LW : GW;
  localparam int unsigned MAXE = (LOCAL_ENTRIES > GLOBAL_ENTRIES) ? LOCAL_ENTRIES : GLOBAL_ENTRIES;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_HIST, S_CNT} state_t;

  logic [LHIST_W-1:0] local_history  [LOCAL_ENTRIES];
  logic [LCNT_W-1:0]  local_counters [LOCAL_ENTRIES];
  logic [GCNT_W-1:0]  global_counters[GLOBAL_ENTRIES];
  logic [GCNT_W-1:0]  choice_counters[GLOBAL_ENTRIES];

  state_t             state;
  logic [MW-1:0]      clr_idx;
  logic [PATH_W-1:0]  path_history;
  logic               last_local_guess;
  logic               last_global_guess;
  logic               last_prediction;

  logic               cmd_q;
  logic               cond_q;
  logic               taken_q;
  logic [LW-1:0]      a_q;
  logic [GW-1:0]      g_q;

  logic [LHIST_W-1:0] lh_q;
  logic [LCNT_W-1:0]  lc_q;
  logic [GCNT_W-1:0]  gc_q;
  logic [GCNT_W-1:0]  ch_q;

  logic               accept;
  logic               is_update;
  logic               advance;
  logic               emit;
  logic               clearing;
  logic [LW-1:0]      a_in;
  logic [GW-1:0]      g_now;
  logic [LW-1:0]      l_idx;
  logic               lg;
  logic               gg;
  logic               pred;
  logic               train_choice;

  function automatic logic gc_sel_local(input logic [GCNT_W-1:0] c);
    return !c[GCNT_W-1];
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign clearing  = (state == S_CLEAR);
  assign a_in      = LW'(branch_address[2 +: LA]);
  assign g_now     = GW'(path_history[GA-1:0]);
  assign l_idx     = LW'(lh_q[LA-1:0]);
  assign is_update = (cmd_q == CMD_UPDATE);
  assign advance   = (state == S_CNT) && (is_update || !out_valid || !out_stall);
  assign emit      = advance && !is_update;

  assign lg           = lc_q[LCNT_W-1];
  assign gg           = gc_q[GCNT_W-1];
  assign pred         = (lg == gg) ? lg : (gc_sel_local(ch_q) ? lg : gg);
  assign train_choice = (last_local_guess != last_global_guess);

  always_ff @(posedge clk) begin
    if (clearing) begin
      local_history[clr_idx[LW-1:0]] <= '0;
    end else if (advance && is_update) begin
      local_history[a_q] <= {lh_q[LHIST_W-2:0], taken_q};
    end
    if (accept) begin
      lh_q <= local_history[a_in];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      local_counters[clr_idx[LW-1:0]] <= '0;
    end else if (advance && is_update) begin
      local_counters[l_idx] <= sat_lcnt(lc_q, taken_q);
    end
    if (state == S_HIST) begin
      lc_q <= local_counters[l_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      global_counters[clr_idx[GW-1:0]] <= '0;
    end else if (advance && is_update) begin
      global_counters[g_q] <= sat_gcnt(gc_q, taken_q);
    end
    if (accept) begin
      gc_q <= global_counters[g_now];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      choice_counters[clr_idx[GW-1:0]] <= '0;
    end else if (advance && is_update && train_choice) begin
      choice_counters[g_q] <= sat_gcnt(ch_q, last_local_guess != taken_q);
    end
    if (accept) begin
      ch_q <= choice_counters[g_now];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      cond_q  <= conditional;
      taken_q <= taken;
      a_q     <= a_in;
      g_q     <= g_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clr_idx           <= '0;
      path_history      <= '0;
      last_local_guess  <= 1'b1;
      last_global_guess <= 1'b1;
      last_prediction   <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == MW'(MAXE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_HIST;
          end
        end
        S_HIST: begin
          state <= S_CNT;
        end
        S_CNT: begin
          if (advance) begin
            state <= S_IDLE;
            if (is_update) begin
              path_history <= {path_history[PATH_W-2:0], taken_q};
            end else begin
              if (cond_q) begin
                last_local_guess  <= lg;
                last_global_guess <= gg;
                last_prediction   <= pred;
                prediction        <= pred;
                local_guess       <= lg;
                global_guess      <= gg;
              end else begin
                prediction        <= last_prediction;
                local_guess       <= last_local_guess;
                global_guess      <= last_global_guess;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
